// ===== rtl/se7_pkg.sv =====
// se7_pkg: shared constants and types of the SysEx eight-to-seven encoder.
// No dependencies; used by every module under rtl/.
package se7_pkg;

  localparam logic [7:0] START_MARK       = 8'hF0;
  localparam logic [7:0] END_MARK         = 8'hF7;
  localparam logic [6:0] FIRST_PREFIX_BIT = 7'h40;
  localparam logic [7:0] LOW_SEVEN        = 8'h7F;
  localparam logic [7:0] TOP_BIT          = 8'h80;

  localparam int GROUP_SIZE        = 7;
  localparam int FILL_W            = 3;
  localparam int QUEUE_DEPTH_DFLT  = 2;

  typedef logic [6:0] sev_t;

  // one command: every output word caused by one input word
  typedef struct packed {
    logic                        start;     // send 0xF0 first
    logic                        send;      // send prefix and group
    logic                        end_mark;  // send 0xF7 last
    logic [FILL_W-1:0]           count;     // group length, 1..7
    sev_t                        prefix;
    sev_t [GROUP_SIZE-1:0]       bytes;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_PREFIX,
    PH_DATA,
    PH_END
  } phase_t;

endpackage

// ===== rtl/se7_front.sv =====
// se7_front: accepts payload words, gathers groups of seven, builds commands.
// Depends on se7_pkg.
module se7_front import se7_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  logic  [7:0] data_byte,
  input  logic  last_of_message,
  input  logic  q_full,
  output push_t q_push
);

  logic                  in_msg;
  logic [FILL_W-1:0]     fill;
  sev_t                  prefix;
  sev_t [GROUP_SIZE-1:0] store;

  logic                  accept;
  logic                  start;
  logic [FILL_W-1:0]     slot;
  logic [FILL_W-1:0]     new_fill;
  sev_t                  prefix0;
  sev_t                  new_prefix;
  sev_t                  low7;
  logic                  top;
  logic                  send;
  sev_t [GROUP_SIZE-1:0] group_now;

  assign full   = q_full;
  assign accept = push & ~q_full;

  always_comb begin
    start      = ~in_msg;
    slot       = start ? '0 : fill;
    prefix0    = start ? '0 : prefix;
    low7       = 7'(data_byte & LOW_SEVEN);
    top        = (data_byte & TOP_BIT) != 8'h00;
    new_prefix = prefix0 | (top ? (FIRST_PREFIX_BIT >> slot) : '0);
    new_fill   = slot + FILL_W'(1);
    send       = (new_fill == FILL_W'(GROUP_SIZE)) | last_of_message;
    group_now       = store;
    group_now[slot] = low7;

    q_push.valid        = accept & (start | send);
    q_push.cmd.start    = start;
    q_push.cmd.send     = send;
    q_push.cmd.end_mark = last_of_message;
    q_push.cmd.count    = new_fill;
    q_push.cmd.prefix   = new_prefix;
    q_push.cmd.bytes    = group_now;
  end

  // group store carries no reset: only slots written this group are read
  always_ff @(posedge clk) begin
    if (accept) begin
      store[slot] <= low7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg <= 1'b0;
      fill   <= '0;
      prefix <= '0;
    end else if (accept) begin
      in_msg <= ~last_of_message;
      fill   <= send ? '0 : new_fill;
      prefix <= send ? '0 : new_prefix;
    end
  end

endmodule

// ===== rtl/se7_queue.sv =====
// se7_queue: small command FIFO decoupling the front from the back.
// Depends on se7_pkg.
module se7_queue import se7_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic  clk,
  input  logic  rst,
  input  push_t q_push,
  input  logic  q_pop,
  output cmd_t  head,
  output logic  q_empty,
  output logic  q_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_empty = count == '0;
  assign q_full  = count == CNT_W'(DEPTH);
  assign do_push = q_push.valid & ~q_full;
  assign do_pop  = q_pop & ~q_empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push & ~do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop & ~do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/se7_back.sv =====
// se7_back: walks the head command and offers one encoded word per cycle while pop is high.
// Depends on se7_pkg.
module se7_back import se7_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic              fresh;
  phase_t            phase;
  logic [FILL_W-1:0] idx;

  phase_t            eff;
  phase_t            phase_next;
  logic [FILL_W-1:0] idx_next;
  logic              done;
  logic              take;

  always_comb begin
    if (fresh) begin
      eff = head.start ? PH_START : (head.send ? PH_PREFIX : PH_END);
    end else begin
      eff = phase;
    end
    phase_next = eff;
    idx_next   = idx;
    done       = 1'b0;
    out_byte   = END_MARK;
    case (eff)
      PH_START: begin
        out_byte = START_MARK;
        if (head.send) begin
          phase_next = PH_PREFIX;
        end else if (head.end_mark) begin
          phase_next = PH_END;
        end else begin
          done = 1'b1;
        end
      end
      PH_PREFIX: begin
        out_byte   = {1'b0, head.prefix};
        phase_next = PH_DATA;
        idx_next   = '0;
      end
      PH_DATA: begin
        out_byte = {1'b0, head.bytes[idx]};
        if ((idx + FILL_W'(1)) < head.count) begin
          idx_next = idx + FILL_W'(1);
        end else if (head.end_mark) begin
          phase_next = PH_END;
        end else begin
          done = 1'b1;
        end
      end
      PH_END: begin
        out_byte = END_MARK;
        done     = 1'b1;
      end
      default: begin
        out_byte = END_MARK;
        done     = 1'b1;
      end
    endcase
  end

  assign empty       = q_empty;
  assign last_of_run = done;
  assign take        = pop & ~q_empty;
  assign q_pop       = take & done;

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
      phase <= PH_START;
      idx   <= '0;
    end else if (take) begin
      fresh <= done;
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== rtl/sysex_eight_to_seven_encoder.sv =====
// sysex_eight_to_seven_encoder: top level; front, command queue and back.
// Path: each command is registered in the queue before the back offers its words.
// Throughput: one input word per cycle while the queue has room; one output word
// per cycle while pop is high, set by the single output port of the back.
// Depends on se7_pkg, se7_front, se7_queue, se7_back.
// Reset: synchronous rst clears group fill, prefix, message flag, queue and walker.
module sysex_eight_to_seven_encoder import se7_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  // Front: tracks message state and the group being gathered. Each input word
  // that causes output becomes one command holding the whole run: start mark,
  // a snapshot of the group with its prefix, and end mark as needed. Words
  // mid-group cause no command at all.
  push_t q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  cmd_t  head;

  se7_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .last_of_message (last_of_message),
    .q_full          (q_full),
    .q_push          (q_push)
  );

  // Queue: lets the front keep taking words while the back drains a run.
  se7_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .head    (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // Back: steps through the head command a word at a time; the command leaves
  // the queue with the last word of its run.
  se7_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  // a run still in progress keeps its command queued
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_run) |=> !empty)
    else $error("run cut short");

  // the end mark always closes its run
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_byte == END_MARK) |-> last_of_run)
    else $error("end mark not last of run");

  // the last word of a message always leaves a command behind
  a_last_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_of_message) |=> !empty)
    else $error("end of message produced no output");

endmodule
